>>> rtl/wrh_pkg.sv
`timescale 1ns / 1ps
// Shared constants, request codes and memory port types for the water ripple block.
// No dependencies.
package wrh_pkg;
    localparam int GRID_SIZE = 128;
    localparam int COORD_W   = $clog2(GRID_SIZE);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int DEPTH     = GRID_SIZE * GRID_SIZE;
    localparam int H_W       = 16;
    localparam int SHIFT_W   = 5;
    localparam int RAD_W     = 8;
    localparam int AMT_W     = 8;
    localparam int REQ_W     = 2;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(4);
    localparam logic [COORD_W-1:0] COORD_MAX   = COORD_W'(GRID_SIZE - 1);

    localparam logic [REQ_W-1:0] REQ_BLOB   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [H_W-1:0]    wdata;
        logic [ADDR_W-1:0] raddr0;
        logic [ADDR_W-1:0] raddr1;
    } t_mem_req;

    typedef struct packed {
        logic [H_W-1:0] rdata0;
        logic [H_W-1:0] rdata1;
    } t_mem_rsp;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_stat;
endpackage

>>> rtl/wrh_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready plus request payload.
// Depends on wrh_pkg.
interface wrh_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [wrh_pkg::REQ_W-1:0]             req_type;
    logic [wrh_pkg::COORD_W-1:0]           pos_x;
    logic [wrh_pkg::COORD_W-1:0]           pos_y;
    logic [wrh_pkg::RAD_W-1:0]             radius;
    logic signed [wrh_pkg::AMT_W-1:0]      amount;

    modport source (output valid, req_type, pos_x, pos_y, radius, amount, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, radius, amount, output ready);
endinterface

>>> rtl/wrh_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready plus the returned height.
// Depends on wrh_pkg.
interface wrh_rsp_if;
    logic                           valid;
    logic                           ready;
    logic signed [wrh_pkg::H_W-1:0] height;

    modport source (output valid, height, input ready);
    modport sink   (input valid, height, output ready);
endinterface

>>> rtl/wrh_ram.sv
`timescale 1ns / 1ps
// Generic synchronous RAM, one write port and two registered read ports.
// No dependencies.
module wrh_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr0,
    input  logic [ADDR_W-1:0] i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule

>>> rtl/wrh_wave_alu.sv
`timescale 1ns / 1ps
// Damped wave update of one cell from neighbor sums and the old value.
// Depends on wrh_pkg.
module wrh_wave_alu (
    input  logic signed [wrh_pkg::H_W:0]        i_ns,
    input  logic signed [wrh_pkg::H_W-1:0]      i_w,
    input  logic signed [wrh_pkg::H_W-1:0]      i_e,
    input  logic signed [wrh_pkg::H_W-1:0]      i_old,
    input  logic        [wrh_pkg::SHIFT_W-1:0]  i_shift,
    output logic        [wrh_pkg::H_W-1:0]      o_res
);
    import wrh_pkg::*;

    logic signed [H_W+1:0] sum4;
    logic signed [H_W:0]   half;
    logic signed [H_W+1:0] s;
    logic signed [H_W+1:0] res;

    always_comb begin
        sum4  = (H_W+2)'(i_ns) + (H_W+2)'(i_w) + (H_W+2)'(i_e);
        half  = sum4[H_W+1:1];
        s     = (H_W+2)'(half) - (H_W+2)'(i_old);
        res   = s - (s >>> i_shift);
        o_res = res[H_W-1:0];
    end
endmodule

>>> rtl/wrh_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: clear sweep, blob read-modify-write, step scan, cell read.
// Depends on wrh_pkg, wrh_req_if, wrh_rsp_if, wrh_wave_alu.
module wrh_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wrh_req_if.sink                      i_req,
    wrh_rsp_if.source                    o_rsp,
    input  logic                         i_cfg_we,
    input  logic [wrh_pkg::SHIFT_W-1:0]  i_cfg_wdata,
    output wrh_pkg::t_mem_req            o_mem_a_req,
    output wrh_pkg::t_mem_req            o_mem_b_req,
    input  wrh_pkg::t_mem_rsp            i_mem_a_rsp,
    input  wrh_pkg::t_mem_rsp            i_mem_b_rsp,
    output wrh_pkg::t_stat               o_stat
);
    import wrh_pkg::*;

    localparam logic [3:0] ST_CLR     = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_BLOB_RD = 4'd2;
    localparam logic [3:0] ST_BLOB_WR = 4'd3;
    localparam logic [3:0] ST_STEP_A  = 4'd4;
    localparam logic [3:0] ST_STEP_B  = 4'd5;
    localparam logic [3:0] ST_STEP_Z  = 4'd6;
    localparam logic [3:0] ST_READ    = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [3:0]               r_state, n_state;
    logic                     r_sel;
    logic [SHIFT_W-1:0]       r_shift;
    logic [COORD_W-1:0]       r_x, r_y, r_x0, r_x1, r_y1, r_px, r_py;
    logic [RAD_W-1:0]         r_r;
    logic signed [AMT_W-1:0]  r_amt;
    logic                     r_hit;
    logic [H_W-1:0]           r_result;
    logic                     r_ovalid;
    logic signed [H_W-1:0]    r_height;
    logic signed [H_W:0]      r_ns;
    logic signed [H_W-1:0]    r_old;
    logic [ADDR_W-1:0]        r_paddr;
    logic                     r_pend;

    t_mem_req cur_req, oth_req;
    t_mem_rsp cur_rsp, oth_rsp;

    logic                     accept, load_out, last_cell, row_end;
    logic signed [COORD_W+2:0] x0s, y0s;
    logic [COORD_W+1:0]       x1s, y1s;
    logic [COORD_W-1:0]       x0, x1, y0, y1;
    logic signed [COORD_W:0]  dx, dy;
    logic signed [H_W-1:0]    dx2, dy2;
    logic [H_W-1:0]           r2;
    logic [H_W:0]             dist_sq;
    logic [H_W-1:0]           alu_res;
    logic [ADDR_W-1:0]        cell_addr;

    assign accept    = i_req.valid && i_req.ready;
    assign load_out  = (r_state == ST_DONE) && (!r_ovalid || o_rsp.ready);
    assign cell_addr = {r_y, r_x};
    assign last_cell = &cell_addr;
    assign row_end   = (r_x + COORD_W'(1)) == r_x1;

    assign i_req.ready  = (r_state == ST_IDLE);
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.height = r_height;
    assign o_stat.clearing = (r_state == ST_CLR);
    assign o_stat.busy     = (r_state != ST_IDLE);

    assign cur_rsp = r_sel ? i_mem_b_rsp : i_mem_a_rsp;
    assign oth_rsp = r_sel ? i_mem_a_rsp : i_mem_b_rsp;
    assign o_mem_a_req = r_sel ? oth_req : cur_req;
    assign o_mem_b_req = r_sel ? cur_req : oth_req;

    wrh_wave_alu u_alu (
        .i_ns    (r_ns),
        .i_w     ($signed(cur_rsp.rdata0)),
        .i_e     ($signed(cur_rsp.rdata1)),
        .i_old   (r_old),
        .i_shift (r_shift),
        .o_res   (alu_res)
    );

    always_comb begin
        x0s = $signed({3'b0, i_req.pos_x}) - $signed({2'b0, i_req.radius});
        y0s = $signed({3'b0, i_req.pos_y}) - $signed({2'b0, i_req.radius});
        x1s = {2'b0, i_req.pos_x} + {1'b0, i_req.radius};
        y1s = {2'b0, i_req.pos_y} + {1'b0, i_req.radius};
        x0  = (x0s < $signed((COORD_W+3)'(1))) ? COORD_W'(1) : x0s[COORD_W-1:0];
        y0  = (y0s < $signed((COORD_W+3)'(1))) ? COORD_W'(1) : y0s[COORD_W-1:0];
        x1  = (x1s > (COORD_W+2)'(COORD_MAX)) ? COORD_MAX : x1s[COORD_W-1:0];
        y1  = (y1s > (COORD_W+2)'(COORD_MAX)) ? COORD_MAX : y1s[COORD_W-1:0];
        dx  = $signed({1'b0, r_x}) - $signed({1'b0, r_px});
        dy  = $signed({1'b0, r_y}) - $signed({1'b0, r_py});
        dx2 = dx * dx;
        dy2 = dy * dy;
        r2  = H_W'(r_r) * H_W'(r_r);
        dist_sq = {1'b0, dx2} + {1'b0, dy2};
    end

    always_comb begin
        cur_req = '0;
        oth_req = '0;
        cur_req.raddr0 = {i_req.pos_y, i_req.pos_x};
        case (r_state)
            ST_CLR: begin
                cur_req.we    = 1'b1;
                cur_req.waddr = cell_addr;
                oth_req.we    = 1'b1;
                oth_req.waddr = cell_addr;
            end
            ST_BLOB_RD: begin
                cur_req.raddr0 = cell_addr;
            end
            ST_BLOB_WR: begin
                cur_req.we    = r_hit;
                cur_req.waddr = cell_addr;
                cur_req.wdata = cur_rsp.rdata0 + H_W'(r_amt);
            end
            ST_STEP_A: begin
                cur_req.raddr0 = {r_y - COORD_W'(1), r_x};
                cur_req.raddr1 = {r_y + COORD_W'(1), r_x};
                oth_req.raddr0 = cell_addr;
                oth_req.we     = r_pend;
                oth_req.waddr  = r_paddr;
                oth_req.wdata  = alu_res;
            end
            ST_STEP_B: begin
                cur_req.raddr0 = {r_y, r_x - COORD_W'(1)};
                cur_req.raddr1 = {r_y, r_x + COORD_W'(1)};
            end
            ST_STEP_Z: begin
                oth_req.we    = 1'b1;
                oth_req.waddr = r_paddr;
                oth_req.wdata = alu_res;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:     if (last_cell) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        REQ_BLOB: n_state = (x0 < x1 && y0 < y1) ? ST_BLOB_RD : ST_DONE;
                        REQ_STEP: n_state = ST_STEP_A;
                        REQ_READ: n_state = ST_READ;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_BLOB_RD: n_state = ST_BLOB_WR;
            ST_BLOB_WR: n_state = (row_end && (r_y + COORD_W'(1)) == r_y1) ? ST_DONE
                                                                            : ST_BLOB_RD;
            ST_STEP_A:  n_state = ST_STEP_B;
            ST_STEP_B:  n_state = last_cell ? ST_STEP_Z : ST_STEP_A;
            ST_STEP_Z:  n_state = ST_DONE;
            ST_READ:    n_state = ST_DONE;
            ST_DONE:    if (load_out) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_sel    <= 1'b0;
            r_shift  <= SHIFT_RESET;
            r_x      <= '0;
            r_y      <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_shift <= i_cfg_wdata;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLR: {r_y, r_x} <= cell_addr + ADDR_W'(1);
                ST_IDLE: begin
                    r_pend <= 1'b0;
                    if (accept) begin
                        r_x <= (i_req.req_type == REQ_BLOB) ? x0 : '0;
                        r_y <= (i_req.req_type == REQ_BLOB) ? y0 : '0;
                    end
                end
                ST_BLOB_WR: begin
                    if (row_end) begin
                        r_x <= r_x0;
                        r_y <= r_y + COORD_W'(1);
                    end else begin
                        r_x <= r_x + COORD_W'(1);
                    end
                end
                ST_STEP_B: begin
                    r_pend <= 1'b1;
                    {r_y, r_x} <= cell_addr + ADDR_W'(1);
                end
                ST_STEP_Z: r_sel <= ~r_sel;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px     <= i_req.pos_x;
            r_py     <= i_req.pos_y;
            r_r      <= i_req.radius;
            r_amt    <= i_req.amount;
            r_x0     <= x0;
            r_x1     <= x1;
            r_y1     <= y1;
            r_result <= '0;
        end
        if (r_state == ST_BLOB_RD) begin
            r_hit <= dist_sq < {1'b0, r2};
        end
        if (r_state == ST_STEP_B) begin
            r_ns    <= (H_W+1)'($signed(cur_rsp.rdata0)) + (H_W+1)'($signed(cur_rsp.rdata1));
            r_old   <= $signed(oth_rsp.rdata0);
            r_paddr <= cell_addr;
        end
        if (r_state == ST_READ) begin
            r_result <= cur_rsp.rdata0;
        end
        if (load_out) begin
            r_height <= $signed(r_result);
        end
    end
endmodule

>>> rtl/water_ripple_heightfield_top.sv
`timescale 1ns / 1ps
// Water ripple height field. A step scans every cell, reading its four neighbours in
// states STEP_A and STEP_B since the source grid memory has two read ports; a blob does
// a read-modify-write over each cell of the clipped bounding box.
// One request in flight; output register holds result, a held result stalls the input.
// Reset runs a clearing pass over both grids; no request taken meanwhile.
// Depends on wrh_pkg, wrh_req_if, wrh_rsp_if, wrh_ram, wrh_ctrl.
module water_ripple_heightfield_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wrh_req_if.sink                      i_req,
    wrh_rsp_if.source                    o_rsp,
    input  logic                         i_cfg_we,
    input  logic [wrh_pkg::SHIFT_W-1:0]  i_cfg_wdata
);
    import wrh_pkg::*;

    t_mem_req mem_a_req, mem_b_req;
    t_mem_rsp mem_a_rsp, mem_b_rsp;
    t_stat    stat;

    wrh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mem_a_req (mem_a_req),
        .o_mem_b_req (mem_b_req),
        .i_mem_a_rsp (mem_a_rsp),
        .i_mem_b_rsp (mem_b_rsp),
        .o_stat      (stat)
    );

    wrh_ram #(.DATA_W(H_W), .ADDR_W(ADDR_W)) u_grid_a (
        .i_clk    (i_clk),
        .i_we     (mem_a_req.we),
        .i_waddr  (mem_a_req.waddr),
        .i_wdata  (mem_a_req.wdata),
        .i_raddr0 (mem_a_req.raddr0),
        .i_raddr1 (mem_a_req.raddr1),
        .o_rdata0 (mem_a_rsp.rdata0),
        .o_rdata1 (mem_a_rsp.rdata1)
    );

    wrh_ram #(.DATA_W(H_W), .ADDR_W(ADDR_W)) u_grid_b (
        .i_clk    (i_clk),
        .i_we     (mem_b_req.we),
        .i_waddr  (mem_b_req.waddr),
        .i_wdata  (mem_b_req.wdata),
        .i_raddr0 (mem_b_req.raddr0),
        .i_raddr1 (mem_b_req.raddr1),
        .o_rdata0 (mem_b_rsp.rdata0),
        .o_rdata1 (mem_b_rsp.rdata1)
    );

    a_one_grid_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_a_req.we && mem_b_req.we) |-> stat.clearing)
        else $error("both grids written outside clearing pass");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !i_req.ready)
        else $error("request taken during clearing pass");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> stat.busy)
        else $error("sequencer idle right after request transfer");
endmodule

>>> dv/wrh_height_checker.sv
`timescale 1ns / 1ps
// Checker for the water ripple block: watches request, response and config ports,
// predicts every response height and compares. Depends on wrh_pkg, wrh_req_if, wrh_rsp_if.
module wrh_height_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wrh_req_if                          i_req,
    wrh_rsp_if                          i_rsp,
    input  logic                        i_cfg_we,
    input  logic [wrh_pkg::SHIFT_W-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import wrh_pkg::*;

    logic signed [H_W-1:0] field [2][DEPTH];
    logic                  cur_sel;
    logic [SHIFT_W-1:0]    decay_shift;
    logic signed [H_W-1:0] heights_due [$];

    task automatic clear_fields();
        for (int i = 0; i < DEPTH; i++) begin
            field[0][i] = '0;
            field[1][i] = '0;
        end
        cur_sel     = 1'b0;
        decay_shift = SHIFT_RESET;
    endtask

    task automatic apply_blob(int cx, int cy, int r, int amt);
        int x0;
        int x1;
        int y0;
        int y1;
        int dx;
        int dy;
        x0 = (cx - r < 1) ? 1 : cx - r;
        y0 = (cy - r < 1) ? 1 : cy - r;
        x1 = (cx + r > GRID_SIZE - 1) ? GRID_SIZE - 1 : cx + r;
        y1 = (cy + r > GRID_SIZE - 1) ? GRID_SIZE - 1 : cy + r;
        for (int y = y0; y < y1; y++) begin
            for (int x = x0; x < x1; x++) begin
                dx = x - cx;
                dy = y - cy;
                if (dx * dx + dy * dy < r * r)
                    field[cur_sel][y * GRID_SIZE + x] =
                        H_W'(int'(field[cur_sel][y * GRID_SIZE + x]) + amt);
            end
        end
    endtask

    task automatic apply_wave_step();
        int n;
        int s;
        int yu;
        int yd;
        int xl;
        int xr;
        for (int y = 0; y < GRID_SIZE; y++) begin
            yu = (y + GRID_SIZE - 1) % GRID_SIZE;
            yd = (y + 1) % GRID_SIZE;
            for (int x = 0; x < GRID_SIZE; x++) begin
                xl = (x + GRID_SIZE - 1) % GRID_SIZE;
                xr = (x + 1) % GRID_SIZE;
                n = int'(field[cur_sel][yu * GRID_SIZE + x])
                  + int'(field[cur_sel][yd * GRID_SIZE + x])
                  + int'(field[cur_sel][y * GRID_SIZE + xl])
                  + int'(field[cur_sel][y * GRID_SIZE + xr]);
                s = (n >>> 1) - int'(field[!cur_sel][y * GRID_SIZE + x]);
                field[!cur_sel][y * GRID_SIZE + x] = H_W'(s - (s >>> decay_shift));
            end
        end
        cur_sel = !cur_sel;
    endtask

    assign o_pending = heights_due.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_fields();
            heights_due.delete();
        end else begin
            if (i_cfg_we)
                decay_shift = i_cfg_wdata;
            if (i_rsp.valid && i_rsp.ready) begin
                if (heights_due.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual height %0d",
                             $time, i_rsp.height);
                    o_fail_count++;
                end else if (heights_due[0] !== i_rsp.height) begin
                    $display("%0t: height mismatch, expected %0d, actual %0d",
                             $time, heights_due[0], i_rsp.height);
                    o_fail_count++;
                    void'(heights_due.pop_front());
                end else begin
                    void'(heights_due.pop_front());
                end
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.req_type)
                    REQ_BLOB: begin
                        apply_blob(int'(i_req.pos_x), int'(i_req.pos_y),
                                   int'(i_req.radius), int'(i_req.amount));
                        heights_due.push_back('0);
                    end
                    REQ_STEP: begin
                        apply_wave_step();
                        heights_due.push_back('0);
                    end
                    REQ_READ: heights_due.push_back(
                        field[cur_sel][int'(i_req.pos_y) * GRID_SIZE + int'(i_req.pos_x)]);
                    default: heights_due.push_back('0);
                endcase
            end
        end
    end
endmodule

>>> dv/tb_water_ripple_heightfield_top.sv
`timescale 1ns / 1ps
// Testbench top for water_ripple_heightfield_top: drives requests and config,
// paces the response side, gives the verdict. Depends on wrh_pkg, the interfaces, the checker.
module tb_water_ripple_heightfield_top;
    import wrh_pkg::*;

    localparam int CYCLE_LIMIT = 20_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [SHIFT_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 pending;
    int                 cycle_cnt;
    logic               calm_mode;
    logic               hold_go;
    int                 hold_left;
    int                 focus_x;
    int                 focus_y;

    wrh_req_if req_ch ();
    wrh_rsp_if rsp_ch ();

    water_ripple_heightfield_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    wrh_height_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // response pacing: long hold-off on request, calm stretch, else random stalls
    always @(posedge i_clk) begin
        if (hold_go && hold_left == 0) begin
            hold_left    <= 400;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            if (hold_left == 1)
                hold_left <= 0;
            rsp_ch.ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 36);
        end
    end

    task automatic send(logic [REQ_W-1:0] kind, int x, int y, int r, int amt);
        if (!calm_mode && $urandom_range(99) < 36) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.pos_x    <= COORD_W'(x);
        req_ch.pos_y    <= COORD_W'(y);
        req_ch.radius   <= RAD_W'(r);
        req_ch.amount   <= AMT_W'(amt);
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic settle_and_config(int shift);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= SHIFT_W'(shift);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                focus_x = $urandom_range(127);
                focus_y = $urandom_range(127);
            end
            if (pick < 4)
                send(REQ_STEP, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 40)
                send(REQ_BLOB, focus_x + $urandom_range(8) - 4, focus_y + $urandom_range(8) - 4,
                     ($urandom_range(49) == 0) ? $urandom_range(200, 255) : $urandom_range(12),
                     $urandom);
            else if (pick < 92)
                send(REQ_READ,
                     ($urandom_range(7) == 0) ? $urandom : focus_x + $urandom_range(12) - 6,
                     ($urandom_range(7) == 0) ? $urandom : focus_y + $urandom_range(12) - 6,
                     $urandom, $urandom);
            else
                send(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        calm_mode       = 1'b0;
        hold_go         = 1'b0;
        focus_x         = 64;
        focus_y         = 64;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_READ;
        req_ch.pos_x    = '0;
        req_ch.pos_y    = '0;
        req_ch.radius   = '0;
        req_ch.amount   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(REQ_READ, 0, 0, 0, 0);
        send(REQ_READ, 127, 127, 255, -128);
        send(REQ_BLOB, 64, 64, 3, 127);
        send(REQ_READ, 64, 64, 0, 0);
        send(REQ_BLOB, 0, 0, 5, -128);
        send(REQ_READ, 1, 1, 0, 0);
        send(REQ_READ, 0, 0, 0, 0);
        send(REQ_BLOB, 20, 20, 0, 100);
        send(REQ_BLOB, 127, 127, 4, 5);
        send(REQ_READ, 126, 126, 0, 0);
        send(REQ_READ, 127, 127, 0, 0);
        send(REQ_UNUSED, 127, 127, 255, -1);
        send(REQ_STEP, 0, 0, 0, 0);
        send(REQ_READ, 64, 64, 0, 0);
        send(REQ_READ, 64, 63, 0, 0);
        send(REQ_STEP, 0, 0, 0, 0);
        send(REQ_READ, 0, 127, 0, 0);
        send(REQ_BLOB, 64, 64, 255, -1);
        send(REQ_READ, 10, 10, 0, 0);
        send(REQ_READ, 0, 5, 0, 0);

        settle_and_config(0);
        random_items(8);
        settle_and_config(31);
        random_items(8);
        hold_go <= 1'b1;
        random_items(6);
        hold_go <= 1'b0;
        settle_and_config(1);
        calm_mode <= 1'b1;
        random_items(8);
        calm_mode <= 1'b0;
        settle_and_config(31);
        // drive one cell past the 16-bit limit
        for (int k = 0; k < 22; k++) begin
            send(REQ_BLOB, 64, 64, 40, 127);
            send(REQ_STEP, 0, 0, 0, 0);
        end
        send(REQ_READ, 64, 64, 0, 0);
        send(REQ_READ, 64, 65, 0, 0);
        settle_and_config($urandom_range(2, 30));
        random_items(6);
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> water_ripple_heightfield_top.f
rtl/wrh_pkg.sv
rtl/wrh_req_if.sv
rtl/wrh_rsp_if.sv
rtl/wrh_ram.sv
rtl/wrh_wave_alu.sv
rtl/wrh_ctrl.sv
rtl/water_ripple_heightfield_top.sv
dv/wrh_height_checker.sv
dv/tb_water_ripple_heightfield_top.sv
